@@ src/iso2ep_pkg.sv @@
// Shared types, constants and helper functions for the ISO-8601 to epoch-seconds core.
// Used by iso2ep_scan, iso2ep_calc and iso8601_to_epoch_seconds_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iso2ep_pkg;

  localparam int EPOCH_W = 39;
  localparam int OUT_W   = 48;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_BAD_SEP  = 2'd2,
    ST_BAD_SIGN = 2'd3
  } status_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [4:0] POS_SAT      = 5'd31;
  localparam logic [4:0] POS_SIGN     = 5'd19;
  localparam logic [4:0] POS_COLON    = 5'd22;
  localparam logic [4:0] POS_LAST_MIN = 5'd18;
  localparam logic [4:0] POS_LAST_OFF = 5'd23;

  typedef struct packed {
    logic [13:0] year;
    logic [15:0] year_bcd;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  off_hours;
    logic [6:0]  off_minutes;
    logic        off_neg;
    logic        use_off;
    status_t     status;
  } snap_t;

  function automatic logic [6:0] acc_digit7(input logic [6:0] v, input logic [3:0] d);
    logic [9:0] s;
    s = {v, 3'b000} + {2'b00, v, 1'b0} + {6'b0, d};
    return s[6:0];
  endfunction

  function automatic logic [13:0] acc_digit14(input logic [13:0] v, input logic [3:0] d);
    logic [16:0] s;
    s = {v, 3'b000} + {2'b00, v, 1'b0} + {13'b0, d};
    return s[13:0];
  endfunction

  function automatic logic [8:0] days_before(input logic [6:0] month, input logic leap);
    logic [8:0] base;
    case (month)
      7'd0:    base = 9'd0;
      7'd1:    base = 9'd0;
      7'd2:    base = 9'd31;
      7'd3:    base = 9'd59;
      7'd4:    base = 9'd90;
      7'd5:    base = 9'd120;
      7'd6:    base = 9'd151;
      7'd7:    base = 9'd181;
      7'd8:    base = 9'd212;
      7'd9:    base = 9'd243;
      7'd10:   base = 9'd273;
      7'd11:   base = 9'd304;
      7'd12:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + {8'b0, leap & (month >= 7'd3)};
  endfunction

endpackage

`default_nettype wire

@@ src/iso2ep_scan.sv @@
// Input register and per-character scanner: field accumulators, separator checks, offset sign.
// Emits one snapshot per string on the last character. Depends on iso2ep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iso2ep_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tlast,
  output logic               snap_valid,
  output iso2ep_pkg::snap_t  snap,
  input  logic               snap_ready
);
  import iso2ep_pkg::*;

  logic        in_v_r;
  logic [7:0]  in_char_r;
  logic        in_last_r;

  logic [4:0]  pos_r, pos_nxt;
  logic [13:0] year_r, year_nxt;
  logic [15:0] bcd_r, bcd_nxt;
  logic [7:1][6:0] fld_r, fld_nxt;
  logic [7:0]  ended_r, ended_nxt;
  logic        neg_r, neg_nxt;
  logic        colon_r, colon_nxt;
  status_t     err_r, err_nxt;

  logic        snap_v_r;
  snap_t       snap_r, snap_nxt;

  logic        snap_free;
  logic        consume;
  logic        digit;
  logic [3:0]  dval;
  logic        colon_set;
  logic [7:0]  fsel;
  logic [7:0]  take;

  assign snap_free = !snap_v_r || snap_ready;
  assign consume   = in_v_r && (!in_last_r || snap_free);
  assign in_tready = !in_v_r || consume;

  assign digit     = (in_char_r >= CH_ZERO) && (in_char_r <= CH_NINE);
  assign dval      = in_char_r[3:0];
  assign colon_set = (pos_r == POS_COLON) && (in_char_r == CH_COLON);

  always_comb begin
    fsel[0] = pos_r <= 5'd3;
    fsel[1] = pos_r inside {5'd5, 5'd6};
    fsel[2] = pos_r inside {5'd8, 5'd9};
    fsel[3] = pos_r inside {5'd11, 5'd12};
    fsel[4] = pos_r inside {5'd14, 5'd15};
    fsel[5] = pos_r inside {5'd17, 5'd18};
    fsel[6] = pos_r inside {5'd20, 5'd21};
    fsel[7] = !colon_set &&
              ((colon_r && (pos_r inside {5'd23, 5'd24})) ||
               (!colon_r && (pos_r inside {5'd22, 5'd23})));
    take    = fsel & ~ended_r;

    ended_nxt = ended_r | (take & {8{!digit}});
    year_nxt  = year_r;
    bcd_nxt   = bcd_r;
    if (take[0] && digit) begin
      year_nxt = acc_digit14(year_r, dval);
      bcd_nxt  = {bcd_r[11:0], dval};
    end
    for (int f = 1; f < 8; f++) begin
      fld_nxt[f] = (take[f] && digit) ? acc_digit7(fld_r[f], dval) : fld_r[f];
    end

    colon_nxt = colon_r | colon_set;
    neg_nxt   = (pos_r == POS_SIGN) ? (in_char_r == CH_DASH) : neg_r;

    err_nxt = err_r;
    if (err_r == ST_OK) begin
      if (((pos_r inside {5'd4, 5'd7}) && (in_char_r != CH_DASH)) ||
          ((pos_r inside {5'd13, 5'd16}) && (in_char_r != CH_COLON))) begin
        err_nxt = ST_BAD_SEP;
      end else if ((pos_r == POS_SIGN) && (in_char_r != CH_PLUS) &&
                   (in_char_r != CH_DASH)) begin
        err_nxt = ST_BAD_SIGN;
      end
    end

    pos_nxt = (pos_r == POS_SAT) ? pos_r : pos_r + 5'd1;

    snap_nxt.year        = year_nxt;
    snap_nxt.year_bcd    = bcd_nxt;
    snap_nxt.month       = fld_nxt[1];
    snap_nxt.day         = fld_nxt[2];
    snap_nxt.hour        = fld_nxt[3];
    snap_nxt.minute      = fld_nxt[4];
    snap_nxt.second      = fld_nxt[5];
    snap_nxt.off_hours   = fld_nxt[6];
    snap_nxt.off_minutes = fld_nxt[7];
    snap_nxt.off_neg     = neg_nxt;
    snap_nxt.use_off     = pos_r >= POS_LAST_OFF;
    if (pos_r < POS_LAST_MIN) begin
      snap_nxt.status = ST_SHORT;
    end else if (err_nxt == ST_BAD_SEP) begin
      snap_nxt.status = ST_BAD_SEP;
    end else if ((err_nxt == ST_BAD_SIGN) && (pos_r >= POS_LAST_OFF)) begin
      snap_nxt.status = ST_BAD_SIGN;
    end else begin
      snap_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (consume && in_last_r)) begin
      pos_r   <= '0;
      year_r  <= '0;
      bcd_r   <= '0;
      fld_r   <= '0;
      ended_r <= '0;
      neg_r   <= 1'b0;
      colon_r <= 1'b0;
      err_r   <= ST_OK;
    end else if (consume) begin
      pos_r   <= pos_nxt;
      year_r  <= year_nxt;
      bcd_r   <= bcd_nxt;
      fld_r   <= fld_nxt;
      ended_r <= ended_nxt;
      neg_r   <= neg_nxt;
      colon_r <= colon_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (snap_free) begin
      snap_v_r <= consume && in_last_r;
    end
    if (snap_free && consume && in_last_r) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

endmodule

`default_nettype wire

@@ src/iso2ep_calc.sv @@
// Result arithmetic: day count and second-of-day stage, then epoch seconds into the result register.
// Takes snapshots from iso2ep_scan. Depends on iso2ep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iso2ep_calc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           snap_valid,
  input  iso2ep_pkg::snap_t              snap,
  output logic                           snap_ready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [iso2ep_pkg::OUT_W-1:0]   out_tdata
);
  import iso2ep_pkg::*;

  logic               mid_v_r;
  logic signed [23:0] days_r, days_nxt;
  logic signed [20:0] sod_r, sod_nxt;
  status_t            status_r;

  logic               out_v_r;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  logic               out_free;
  logic               mid_free;

  logic               m4, cent, m400, leap;
  logic [8:0]         db;
  logic signed [14:0] yr_s, yoff, ydiff, yq;
  logic signed [10:0] yday;
  logic [18:0]        base_s, off_s;
  logic signed [40:0] t_full;
  logic [EPOCH_W-1:0] epoch;

  assign out_free   = !out_v_r || out_tready;
  assign mid_free   = !mid_v_r || out_free;
  assign snap_ready = mid_free;

  always_comb begin
    m4   = ({snap.year_bcd[4], 1'b0} + snap.year_bcd[1:0]) == 2'd0;
    cent = snap.year_bcd[7:0] == 8'h00;
    m400 = ({snap.year_bcd[12], 1'b0} + snap.year_bcd[9:8]) == 2'd0;
    leap = m4 && !(cent && !m400);
    db   = days_before(snap.month, leap);

    yr_s  = signed'({1'b0, snap.year});
    yoff  = yr_s - 15'sd1970;
    ydiff = yr_s - 15'sd1969;
    yq    = (ydiff + (ydiff[14] ? 15'sd3 : 15'sd0)) >>> 2;
    yday  = signed'({2'b00, db}) + signed'({4'b0000, snap.day}) - 11'sd1;
    days_nxt = 24'(yoff) * 24'sd365 + 24'(yday) + 24'(yq);

    base_s = 19'(snap.second) + 19'(snap.minute) * 19'd60 + 19'(snap.hour) * 19'd3600;
    off_s  = snap.use_off ?
             (19'(snap.off_hours) * 19'd3600 + 19'(snap.off_minutes) * 19'd60) : 19'd0;
    sod_nxt = snap.off_neg ? (signed'({2'b00, base_s}) - signed'({2'b00, off_s}))
                           : (signed'({2'b00, base_s}) + signed'({2'b00, off_s}));
  end

  always_comb begin
    t_full       = 41'(days_r) * 41'sd86400 + 41'(sod_r);
    epoch        = (status_r == ST_OK) ? t_full[EPOCH_W-1:0] : '0;
    out_data_nxt = {{(OUT_W - EPOCH_W - 2){1'b0}}, status_r, epoch};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0;
    end else if (mid_free) begin
      mid_v_r <= snap_valid;
    end
    if (mid_free && snap_valid) begin
      days_r   <= days_nxt;
      sod_r    <= sod_nxt;
      status_r <= snap.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= mid_v_r;
    end
    if (out_free && mid_v_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ src/iso8601_to_epoch_seconds_core.sv @@
// Top level of the ISO-8601 date-time to epoch-seconds converter.
// Instantiates iso2ep_scan and iso2ep_calc; depends on iso2ep_pkg.
//
//   Channel  Dir  Handshake            Payload
//   in_      in   in_tvalid/in_tready  tdata[7:0] char_in, tlast is_last
//   out_     out  out_tvalid/out_tready tdata[38:0] epoch_seconds, [40:39] status
//
// One character per cycle, but a last character waits while the snapshot register is full and not taken.
// A result passes the input, snapshot and day-count registers to the result register.
// Synchronous active-low reset clears the handshakes and the scan state.
// A stalled result holds only the stages behind it that still carry a request.
`timescale 1ns / 1ps
`default_nettype none

module iso8601_to_epoch_seconds_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] char_in
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [iso2ep_pkg::OUT_W-1:0]  out_tdata   // [38:0] epoch_seconds, [40:39] status
);
  import iso2ep_pkg::*;

  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  iso2ep_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  iso2ep_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[EPOCH_W+1:EPOCH_W] != 2'(ST_OK)) |->
      out_tdata[EPOCH_W-1:0] == '0)
    else $error("error result carries nonzero seconds");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  a_short_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid && (snap.status == ST_BAD_SIGN) |-> snap.use_off)
    else $error("offset sign error on string without offset");

endmodule

`default_nettype wire
